// ===== sv/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// shared types, round constants and helper functions for the sha-256 core
// ----------------------------------------------------------------------------
package sha256_pkg;

    // front to back request: one block ready to compress
    typedef struct packed {
        logic [511:0] block;     // sixteen words, word 0 in the top bits
        logic         last;      // final block of the message
    } t_blk_req;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k [0:63];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[idx];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== sv/sha256_front.sv =====
// ----------------------------------------------------------------------------
// sha256_front
// packs message bytes into 64-byte blocks and appends the padding
// ----------------------------------------------------------------------------
module sha256_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_byte,
    input  logic                  i_has_byte,
    input  logic                  i_end,
    input  logic                  i_valid,
    output logic                  o_ready,
    output sha256_pkg::t_blk_req  o_req,
    output logic                  o_req_valid,
    input  logic                  i_req_ready
);
    import sha256_pkg::*;

    typedef enum logic [1:0] {S_FILL, S_PAD, S_LEN} t_state;

    t_state        r_state;
    logic [511:0]  r_buf;
    logic [63:0]   r_count;
    logic [63:0]   r_bits;
    t_blk_req      r_req;
    logic          r_req_valid;
    logic [5:0]    r_pos;

    logic          slot_free;
    logic          take;
    logic [511:0]  pad_block;

    assign slot_free   = !r_req_valid || i_req_ready;
    assign o_ready     = (r_state == S_FILL) && slot_free;
    assign take        = i_valid && o_ready;
    assign o_req       = r_req;
    assign o_req_valid = r_req_valid;

    // block with byte placed at position p, later bytes zeroed
    function automatic logic [511:0] put(input logic [511:0] b, input logic [5:0] p,
                                         input logic [7:0] v);
        logic [511:0] o;
        o = b;
        for (int i = 0; i < 64; i++) begin
            if (i[5:0] == p) o[511 - 8*i -: 8] = v;
            else if (i[5:0] > p) o[511 - 8*i -: 8] = 8'h00;
        end
        return o;
    endfunction

    // current block closed by the pad byte
    assign pad_block = put(r_buf, r_pos, PAD_BYTE);

    // byte packing, padding sequencer and output request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_count     <= '0;
            r_req_valid <= 1'b0;
        end else begin
            if (i_req_ready) r_req_valid <= 1'b0;
            unique case (r_state)
                S_FILL: begin
                    if (take) begin
                        if (i_has_byte) begin
                            r_buf   <= put(r_buf, r_count[5:0], i_byte);
                            r_count <= r_count + 64'd1;
                            if (r_count[5:0] == 6'd63) begin
                                r_req.block <= put(r_buf, r_count[5:0], i_byte);
                                r_req.last  <= 1'b0;
                                r_req_valid <= 1'b1;
                            end
                            if (i_end) begin
                                r_state <= S_PAD;
                                r_pos   <= r_count[5:0] + 6'd1;
                                r_bits  <= (r_count + 64'd1) << 3;
                            end
                        end else if (i_end) begin
                            r_state <= S_PAD;
                            r_pos   <= r_count[5:0];
                            r_bits  <= r_count << 3;
                        end
                    end
                end
                S_PAD: begin
                    if (slot_free) begin
                        r_req_valid <= 1'b1;
                        if (r_pos >= 6'd56) begin
                            r_req.block <= pad_block;
                            r_req.last  <= 1'b0;
                            r_state     <= S_LEN;
                        end else begin
                            r_req.block <= {pad_block[511:64], r_bits};
                            r_req.last  <= 1'b1;
                            r_state     <= S_FILL;
                            r_count     <= '0;
                        end
                    end
                end
                S_LEN: begin
                    if (slot_free) begin
                        r_req_valid <= 1'b1;
                        r_req.block <= {448'd0, r_bits};
                        r_req.last  <= 1'b1;
                        r_state     <= S_FILL;
                        r_count     <= '0;
                    end
                end
                default: r_state <= S_FILL;
            endcase
        end
    end

    // a held request never changes under a stall
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_valid && !i_req_ready |=> r_req_valid && $stable(r_req))
        else $error("front request changed while stalled");
    // no input taken while padding
    a_no_take_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_FILL |-> !o_ready)
        else $error("input accepted during padding");
    // a full block is requested when the byte counter wraps
    a_wrap_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_has_byte && r_count[5:0] == 6'd63 |=> r_req_valid)
        else $error("full block not requested");

endmodule

// ===== sv/sha256_queue.sv =====
// ----------------------------------------------------------------------------
// sha256_queue
// two-entry block queue between packing and compression
// ----------------------------------------------------------------------------
module sha256_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_blk_req  i_req,
    input  logic                  i_valid,
    output logic                  o_ready,
    output sha256_pkg::t_blk_req  o_req,
    output logic                  o_valid,
    input  logic                  i_ready
);
    import sha256_pkg::*;

    t_blk_req    r_mem [0:1];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    logic        pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_req;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue level out of range");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp)
        else $error("queue pointers disagree with level");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 && !pop |=> r_cnt == 2'd2)
        else $error("queue level lost an entry");

endmodule

// ===== sv/sha256_back.sv =====
// ----------------------------------------------------------------------------
// sha256_back
// one round per cycle compression and digest word output
// ----------------------------------------------------------------------------
module sha256_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_blk_req  i_req,
    input  logic                  i_valid,
    output logic                  o_ready,
    output logic [31:0]           o_word,
    output logic [2:0]            o_index,
    output logic                  o_last,
    output logic                  o_valid,
    input  logic                  i_ready
);
    import sha256_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ROUND, S_ADD, S_OUT} t_state;

    t_state         r_state;
    logic [255:0]   r_chain;
    logic [255:0]   r_v;
    logic [511:0]   r_w;     // sliding message schedule window, w[i] at top
    logic [5:0]     r_rnd;
    logic           r_last;
    logic [2:0]     r_idx;

    logic [31:0] a, b, c, d, e, f, g, h, w0, t1, t2, s0, s1, wn;

    always_comb begin
        {a, b, c, d, e, f, g, h} = r_v;
        w0 = r_w[511:480];
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + round_k(r_rnd) + w0;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        s0 = rotr(r_w[479:448], 7) ^ rotr(r_w[479:448], 18) ^ (r_w[479:448] >> 3);
        s1 = rotr(r_w[63:32], 17) ^ rotr(r_w[63:32], 19) ^ (r_w[63:32] >> 10);
        wn = w0 + s0 + r_w[223:192] + s1;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_word  = r_chain[255 - 32*r_idx -: 32];
    assign o_index = r_idx;
    assign o_last  = (r_idx == 3'd7);

    // compression sequencer and digest output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chain <= INIT_HASH;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_w     <= i_req.block;
                    r_last  <= i_req.last;
                    r_v     <= r_chain;
                    r_rnd   <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_v   <= {t1 + t2, a, b, c, d + t1, e, f, g};
                    r_w   <= {r_w[479:0], wn};
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++)
                        r_chain[32*i +: 32] <= r_chain[32*i +: 32] + r_v[32*i +: 32];
                    r_idx   <= '0;
                    r_state <= r_last ? S_OUT : S_IDLE;
                end
                S_OUT: if (i_ready) begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        r_chain <= INIT_HASH;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(r_idx))
        else $error("digest word changed under stall");
    a_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last |=> r_chain == INIT_HASH)
        else $error("chain not restored after digest");
    a_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROUND && r_rnd == 6'd63 |=> r_state == S_ADD)
        else $error("round count mismatch");

endmodule

// ===== sv/sha256_message_hasher_core.sv =====
// ----------------------------------------------------------------------------
// sha256_message_hasher_core
// streaming sha-256 hasher, one message byte per request
// ----------------------------------------------------------------------------
// usage:
//   slave channel carries one byte per request: tdata = msg_byte,
//   tuser = has_byte, tlast = end_of_message. has_byte low with tlast
//   high closes a message without adding a byte.
//   master channel returns the eight digest words after each tlast:
//   tdata = digest_word, tuser = word_index, tlast = last_word.
// throughput: bytes are taken one per cycle in the fill state while the
//   block queue has room; each 64-byte block then passes the round and add
//   states of the single round unit, which sets the sustained rate (about
//   one byte per cycle). a message end costs one or two padding blocks.
// digest: after the closing request each padding block passes the queue and
//   the round and add states, then the output state shows the first word.
// reset: synchronous active low; the chain returns to the initial hash
//   and the byte count to zero. a stalled master holds its word and, once
//   the queue fills, back-pressures the slave side.
// ----------------------------------------------------------------------------
module sha256_message_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);
    import sha256_pkg::*;

    t_blk_req f_req;
    t_blk_req q_req;
    logic     f_valid, f_ready, q_valid, q_ready;

    // byte packing and padding
    sha256_front u_front (
        .i_clk, .i_rst_n,
        .i_byte(s_axis_tdata), .i_has_byte(s_axis_tuser), .i_end(s_axis_tlast),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .o_req(f_req), .o_req_valid(f_valid), .i_req_ready(f_ready)
    );

    // decoupling queue
    sha256_queue u_queue (
        .i_clk, .i_rst_n,
        .i_req(f_req), .i_valid(f_valid), .o_ready(f_ready),
        .o_req(q_req), .o_valid(q_valid), .i_ready(q_ready)
    );

    // compression and digest output
    sha256_back u_back (
        .i_clk, .i_rst_n,
        .i_req(q_req), .i_valid(q_valid), .o_ready(q_ready),
        .o_word(m_axis_tdata), .o_index(m_axis_tuser), .o_last(m_axis_tlast),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready)
    );

endmodule

// ===== test/sha256_digest_checker.sv =====
// ----------------------------------------------------------------------------
// sha256_digest_checker
// watches both streams, computes the sha-256 digest of each message from the
// accepted bytes and compares every digest word returned by the core
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sha256_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_has,
    input  logic        i_in_end,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_word,
    input  logic [2:0]  i_out_index,
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_digests_seen
);
    import sha256_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic [31:0]  chain [8];
    logic [31:0]  msg_block [16];
    logic [63:0]  msg_bytes;
    t_digest_word digest_q [$];

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of msg_block into chain
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        for (int i = 0; i < 16; i++) w[i] = msg_block[i];
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                    chain[4], chain[5], chain[6], chain[7]};
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
                 + ((e & f) ^ (~e & g)) + k[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
                 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    // big-endian byte placement; the first byte of a word clears it
    task automatic place_byte(int pos, logic [7:0] value);
        if (pos % 4 == 0) msg_block[pos / 4] = '0;
        msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = value;
    endtask

    task automatic restart_chain();
        for (int i = 0; i < 8; i++) chain[i] = INIT_HASH[255 - 32 * i -: 32];
        msg_bytes = '0;
    endtask

    // absorb one request, and on a message end pad and queue the digest
    task automatic absorb_request(logic [7:0] value, logic has, logic fin);
        int pos;
        logic [63:0] bit_len;
        if (has) begin
            place_byte(int'(msg_bytes[5:0]), value);
            msg_bytes++;
            if (msg_bytes[5:0] == 6'd0) compress_block();
        end
        if (fin) begin
            bit_len = msg_bytes << 3;
            pos = int'(msg_bytes[5:0]);
            place_byte(pos, PAD_BYTE);
            for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
            if (pos >= 56) begin
                compress_block();
                for (int i = 0; i < 16; i++) msg_block[i] = '0;
            end
            msg_block[14] = bit_len[63:32];
            msg_block[15] = bit_len[31:0];
            compress_block();
            for (int i = 0; i < 8; i++)
                digest_q.push_back('{word: chain[i], index: 3'(i), last: (i == 7)});
            restart_chain();
        end
    endtask

    initial begin
        restart_chain();
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
    end

    assign o_pending = digest_q.size();

    // sample both channels at the edge, after the drivers have settled
    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) absorb_request(i_in_byte, i_in_has, i_in_end);
            if (i_out_valid && i_out_ready) begin
                if (digest_q.size() == 0) begin
                    $error("digest word %h with no digest outstanding", i_out_word);
                    o_fail_count++;
                end else begin
                    exp_w = digest_q.pop_front();
                    if (i_out_word !== exp_w.word) begin
                        $error("digest_word: expected %h, got %h", exp_w.word, i_out_word);
                        o_fail_count++;
                    end
                    if (i_out_index !== exp_w.index) begin
                        $error("word_index: expected %0d, got %0d", exp_w.index, i_out_index);
                        o_fail_count++;
                    end
                    if (i_out_last !== exp_w.last) begin
                        $error("last_word: expected %0d, got %0d", exp_w.last, i_out_last);
                        o_fail_count++;
                    end
                    if (exp_w.last) o_digests_seen++;
                end
            end
        end
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives byte streams of assorted lengths into the sha-256 core under random
// stalls on both sides; the checker predicts and compares every digest word
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] msg_byte
    logic        s_axis_tuser;   // [0] has_byte
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] digest_word
    logic [2:0]  m_axis_tuser;   // [2:0] word_index
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int digests_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;
    int requests_sent;

    sha256_message_hasher_core dut (.*);

    sha256_digest_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_byte      (s_axis_tdata),
        .i_in_has       (s_axis_tuser),
        .i_in_end       (s_axis_tlast),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_word     (m_axis_tdata),
        .i_out_index    (m_axis_tuser),
        .i_out_last     (m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_digests_seen (digests_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // one request, held until accepted; random idle cycles ahead of it
    // drop valid only while idling so back-to-back requests keep it high
    task automatic send_request(logic [7:0] value, logic has, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= has;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        requests_sent++;
    endtask

    // message of len random bytes; mode 1 sprinkles empty requests,
    // mode 2 closes with a data-less end request
    task automatic send_message(int len, int mode);
        for (int i = 0; i < len; i++) begin
            if (mode == 1 && $urandom_range(3) == 0)
                send_request(8'($urandom), 1'b0, 1'b0);
            send_request(8'($urandom), 1'b1, (mode != 2) && (i == len - 1));
        end
        if (mode == 2 || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready   <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = 1'b0;
        s_axis_tlast    = 1'b0;
        m_axis_tready   = 1'b0;
        hold_off_cycles = 0;
        requests_sent   = 0;
        send_idle_pct   = 11;
        recv_idle_pct   = 85;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, byte extremes, data-less end, short messages
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h00, 1'b0, 1'b0);
        send_request(8'hff, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hff, 1'b1, 1'b0);
        send_request(8'h5a, 1'b0, 1'b1);
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        wait_drained();

        // random messages, some with lengths around the padding edges
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 85;
                recv_idle_pct = 11;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int m = 0; m < 4; m++) begin
                case ($urandom_range(3))
                    0: send_message(55 + $urandom_range(9), $urandom_range(2));
                    1: send_message($urandom_range(3), $urandom_range(2));
                    default: send_message($urandom_range(20), $urandom_range(2));
                endcase
            end
            // sender pause until every digest is back
            wait_drained();
        end

        // long receiver hold-off while a long message fills the queues
        @(posedge i_clk);
        hold_off_cycles <= 600;
        send_message(128, 0);
        send_message(3, 0);
        send_message(0, 0);
        while (requests_sent < 380) send_message($urandom_range(40), $urandom_range(2));

        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("summary: %0d requests sent, %0d digests checked (empty, padding-edge,",
                 requests_sent, digests_seen);
        $display("         multi-block and data-less end messages under stalls)");
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
